// ----- design/imaenc_pkg.sv -----
// Package with the step-size table, index adjust table and shared types of the IMA ADPCM encoder.
`timescale 1ns / 1ps
`default_nettype none

package imaenc_pkg;

    // Field widths fixed by the sample and code formats.
    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 4;
    localparam int INDEX_W  = 7;
    localparam int STEP_W   = 15;
    localparam int MAG_W    = 17;

    // Highest legal step table index.
    localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;

    // Saturation limits of the predictor.
    localparam logic signed [SAMPLE_W-1:0] PRED_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] PRED_MIN = 16'sh8000;

    // Code bit positions.
    localparam int CODE_SIGN = 3;
    localparam int CODE_B2   = 2;
    localparam int CODE_B1   = 1;
    localparam int CODE_B0   = 0;

    // Encoder state carried from one word to the next.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] predictor;
        logic [INDEX_W-1:0]         step_index;
    } imaenc_state_t;

    // Standard 89-entry IMA step table; indexes past the end clamp to the last entry.
    function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        begin
            case (idx)
                7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
                7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
                7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
                7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
                7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
                7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
                7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
                7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
                7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
                7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
                7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
                7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
                7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
                7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
                7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
                7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
                7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
                7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

    // Index adjustment by the three magnitude bits of the code.
    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        begin
            case (mag)
                3'd4:    a = 5'sd2;
                3'd5:    a = 5'sd4;
                3'd6:    a = 5'sd6;
                3'd7:    a = 5'sd8;
                default: a = -5'sd1;
            endcase
            return a;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/ima_adpcm_encoder_unit.sv -----
// Top level of the IMA ADPCM encoder: input register, quantizer, state and result register.
//
// Usage: each input word on in_valid/in_ready carries one signed 16-bit PCM
// sample in pcm_sample; each output word on out_valid/out_ready carries the
// 4-bit IMA ADPCM code in code_nibble (bit 3 sign, bits 2..0 magnitude).
// Exactly one code leaves for every sample taken, in order.
// Path: a sample accepted on the input passes the input register, then the
// result register, before its code shows on the output.
// Throughput: one word per cycle while out_ready stays high. The quantizer and
// the state update sit between the input register and the result register, and
// the predictor and step index are written in the same cycle the code is
// registered, so the next sample sees the new state at once.
// Reset: rst_n clears the predictor and the step index to zero and empties
// both registers.
// Stalls: while out_ready is low the finished code waits in the result
// register; one more sample can still be taken into the input register, and
// in_ready drops only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module ima_adpcm_encoder_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [imaenc_pkg::SAMPLE_W-1:0] pcm_sample,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [imaenc_pkg::CODE_W-1:0]               code_nibble
);
    import imaenc_pkg::*;

    logic                         in_valid_reg;
    logic signed [SAMPLE_W-1:0]   sample_reg;
    logic                         out_valid_reg;
    logic [CODE_W-1:0]            code_reg;
    logic                         advance;
    logic [CODE_W-1:0]            code;
    logic [MAG_W-1:0]             delta;
    imaenc_state_t                state;

    // A held sample moves on when the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sample_reg <= pcm_sample;
        end
    end

    // Quantizer on the held sample.
    imaenc_quant u_quant (
        .sample (sample_reg),
        .state  (state),
        .code   (code),
        .delta  (delta)
    );

    // Predictor and index advance with each word that moves on.
    imaenc_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .code   (code),
        .delta  (delta),
        .state  (state)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_reg <= code;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_nibble = code_reg;

    // The step index never leaves the table.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state.step_index <= INDEX_MAX)
        else $error("step index above table end");

    // A word that moves on is always shown on the output next cycle.
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word not presented");

    // State changes only when a word moves on.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state))
        else $error("encoder state changed without a word");

    // A waiting result is never overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result overwritten during stall");

endmodule

`default_nettype wire

// ----- design/imaenc_quant.sv -----
// Quantizer: turns a sample and the current state into a code and its rebuilt delta.
`timescale 1ns / 1ps
`default_nettype none

module imaenc_quant (
    input  wire logic signed [imaenc_pkg::SAMPLE_W-1:0] sample,
    input  wire imaenc_pkg::imaenc_state_t              state,
    output logic [imaenc_pkg::CODE_W-1:0]               code,
    output logic [imaenc_pkg::MAG_W-1:0]                delta
);
    import imaenc_pkg::*;

    logic [STEP_W-1:0]        step;
    logic [MAG_W-1:0]         step_x;
    logic [MAG_W-1:0]         half_x;
    logic [MAG_W-1:0]         quarter_x;
    logic signed [MAG_W-1:0]  diff;
    logic [MAG_W-1:0]         mag0;
    logic [MAG_W-1:0]         mag1;
    logic [MAG_W-1:0]         mag2;
    logic                     neg;
    logic                     b2;
    logic                     b1;
    logic                     b0;

    // Step size of the current index, widened for the compares.
    assign step      = step_lookup(state.step_index);
    assign step_x    = {{(MAG_W-STEP_W){1'b0}}, step};
    assign half_x    = step_x >> 1;
    assign quarter_x = step_x >> 2;

    // Difference to the prediction and its magnitude.
    assign diff = {sample[SAMPLE_W-1], sample} - {state.predictor[SAMPLE_W-1], state.predictor};
    assign neg  = diff[MAG_W-1];
    assign mag0 = neg ? MAG_W'(-diff) : MAG_W'(diff);

    // Three compare steps against step, step/2 and step/4, subtracting after the first two.
    assign b2   = (mag0 >= step_x);
    assign mag1 = b2 ? (mag0 - step_x) : mag0;
    assign b1   = (mag1 >= half_x);
    assign mag2 = b1 ? (mag1 - half_x) : mag1;
    assign b0   = (mag2 >= quarter_x);

    always_comb
    begin
        code            = '0;
        code[CODE_SIGN] = neg;
        code[CODE_B2]   = b2;
        code[CODE_B1]   = b1;
        code[CODE_B0]   = b0;
    end

    // Rebuilt delta magnitude, including the step/8 term.
    assign delta = (step_x >> 3)
                 + (b2 ? step_x : '0)
                 + (b1 ? half_x : '0)
                 + (b0 ? quarter_x : '0);

endmodule

`default_nettype wire

// ----- design/imaenc_state.sv -----
// State registers: predictor and step index with saturating and clamped updates.
`timescale 1ns / 1ps
`default_nettype none

module imaenc_state (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          update,
    input  wire logic [imaenc_pkg::CODE_W-1:0] code,
    input  wire logic [imaenc_pkg::MAG_W-1:0]  delta,
    output imaenc_pkg::imaenc_state_t          state
);
    import imaenc_pkg::*;

    imaenc_state_t             state_reg;
    imaenc_state_t             state_next;
    logic signed [MAG_W:0]     pred_sum;
    logic signed [MAG_W:0]     delta_s;
    logic signed [INDEX_W:0]   idx_sum;
    logic signed [4:0]         adj;

    // Signed delta applied to the predictor.
    assign delta_s  = code[CODE_SIGN] ? -$signed({1'b0, delta}) : $signed({1'b0, delta});
    assign pred_sum = $signed({{(MAG_W+1-SAMPLE_W){state_reg.predictor[SAMPLE_W-1]}},
                               state_reg.predictor}) + delta_s;

    // Index moves by the adjust table.
    assign adj     = index_adjust(code[2:0]);
    assign idx_sum = $signed({1'b0, state_reg.step_index})
                   + $signed({{(INDEX_W+1-5){adj[4]}}, adj});

    // Saturate the predictor and clamp the index.
    always_comb
    begin
        state_next = state_reg;
        if (pred_sum > $signed({{(MAG_W+1-SAMPLE_W){1'b0}}, PRED_MAX}))
        begin
            state_next.predictor = PRED_MAX;
        end
        else if (pred_sum < $signed({{(MAG_W+1-SAMPLE_W){1'b1}}, PRED_MIN}))
        begin
            state_next.predictor = PRED_MIN;
        end
        else
        begin
            state_next.predictor = pred_sum[SAMPLE_W-1:0];
        end

        if (idx_sum[INDEX_W])
        begin
            state_next.step_index = '0;
        end
        else if (idx_sum[INDEX_W-1:0] > INDEX_MAX)
        begin
            state_next.step_index = INDEX_MAX;
        end
        else
        begin
            state_next.step_index = idx_sum[INDEX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (update)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire
